// File: rtl/core/sorted_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared shorthand for the concurrent checks on the queue ports.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types, codes and widths for the queue cells and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Default number of cells in the chain.
    localparam int DEPTH_DEFAULT = 16;

    // Fixed field widths.
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;

    // Operation codes carried on the input tuser.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    // Result status codes carried on the output tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NO_MATCH = 2'd2
    } status_t;

    // One stored entry as handed between neighboring cells.
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } entry_t;

    // Command broadcast to every cell.
    typedef struct packed {
        logic                      en;
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } cmd_t;

    // Decision chain running from the head cell toward the tail.
    typedef struct packed {
        logic ins_gt;   // this cell or one nearer the head takes the new entry
        logic rm_hit;   // a match was found at this cell or nearer the head
    } link_t;

endpackage

`default_nettype wire

// File: rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry and decides locally whether to keep it, take the new entry,
// take the left neighbor (insert shift) or take the right neighbor (remove).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  spq_pkg::cmd_t       cmd,
    input  spq_pkg::entry_t     left_entry,
    input  spq_pkg::entry_t     right_entry,
    input  spq_pkg::link_t      link_in,
    output spq_pkg::link_t      link_out,
    output spq_pkg::entry_t     entry,
    output spq_pkg::entry_t     entry_next
);

    logic                               valid_reg;
    logic signed [spq_pkg::VALUE_W-1:0] value_reg;
    logic [spq_pkg::PRIO_W-1:0]         prio_reg;

    logic below;
    logic match;

    // Local compares against the broadcast command.
    always_comb begin
        below           = valid_reg && (prio_reg < cmd.prio);
        match           = valid_reg && (value_reg == cmd.value);
        link_out.ins_gt = !below;
        link_out.rm_hit = link_in.rm_hit | match;
    end

    assign entry = '{valid: valid_reg, value: value_reg, prio: prio_reg};

    // Next contents: hold, take new, shift from left or shift from right.
    always_comb begin
        entry_next = entry;
        if (cmd.en) begin
            case (cmd.op)
                spq_pkg::OP_INSERT: begin
                    if (link_in.ins_gt) begin
                        entry_next = left_entry;
                    end else if (!below) begin
                        entry_next = '{valid: 1'b1, value: cmd.value, prio: cmd.prio};
                    end
                end
                spq_pkg::OP_REMOVE: begin
                    if (link_out.rm_hit) begin
                        entry_next = right_entry;
                    end
                end
                default: begin
                    entry_next = entry;
                end
            endcase
        end
    end

    // Valid flag is control state; the payload needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= entry_next.value;
        prio_reg  <= entry_next.prio;
    end

endmodule

`default_nettype wire

// File: rtl/core/sorted_priority_queue.sv
// Result: a result word is registered and appears in the cycle after its input is accepted.
// Throughput: one insert or remove per cycle while results are taken; all cells
// compare and shift in the same cycle; the output register holds a result until taken.
// Reset: aresetn low clears all cell valid flags, the occupancy count and the
// output valid; the queue comes out of reset empty and ready at once.
// ----------------------------------------------------------------------------
// Sorted priority queue
// A chain of DEPTH cells kept in ascending priority order, with insert by
// local compare and shift and remove of the first matching value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [spq_pkg::S_DATA_W-1:0]  s_tdata,  // value[31:0], priority_req[47:32]
    input  wire logic [0:0]                    s_tuser,  // op[0]
    // Result stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [spq_pkg::M_DATA_W-1:0]       m_tdata,  // count[4:0], head_valid[5],
                                                         // head_value[37:6],
                                                         // head_priority[53:38], zero[55:54]
    output logic [spq_pkg::STATUS_W-1:0]       m_tuser   // status[1:0]
);

    localparam int CntW = $clog2(DEPTH + 1);

    spq_pkg::cmd_t   cmd;
    spq_pkg::link_t  link  [DEPTH+1];
    spq_pkg::entry_t ent   [DEPTH];
    spq_pkg::entry_t nxt   [DEPTH];

    logic            s_accept;
    logic            full;
    logic            found;
    spq_pkg::op_t    op;

    logic [CntW-1:0] occ_reg;
    logic [CntW-1:0] occ_next;

    logic                                m_tvalid_reg;
    spq_pkg::status_t                    status_reg;
    spq_pkg::status_t                    status_next;
    logic [spq_pkg::COUNT_W-1:0]         count_reg;
    spq_pkg::entry_t                     head_reg;

    // Input handshake: a new word is taken whenever the output slot frees up,
    // and never while reset is held.
    assign s_tready = aresetn && (!m_tvalid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign op       = spq_pkg::op_t'(s_tuser[0]);
    assign full     = ent[DEPTH-1].valid;
    assign found    = link[DEPTH].rm_hit;

    // Broadcast command; an insert into a full queue changes nothing.
    always_comb begin
        cmd.en    = s_accept && !((op == spq_pkg::OP_INSERT) && full);
        cmd.op    = op;
        cmd.value = s_tdata[spq_pkg::VALUE_W-1:0];
        cmd.prio  = s_tdata[spq_pkg::VALUE_W +: spq_pkg::PRIO_W];
    end

    assign link[0] = '0;

    // The chain of cells, head at index zero.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_pkg::entry_t left_w;
        spq_pkg::entry_t right_w;

        if (i == 0) begin : g_head
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = ent[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = ent[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .left_entry  (left_w),
            .right_entry (right_w),
            .link_in     (link[i]),
            .link_out    (link[i+1]),
            .entry       (ent[i]),
            .entry_next  (nxt[i])
        );
    end

    // Occupancy and result status.
    always_comb begin
        occ_next    = occ_reg;
        status_next = spq_pkg::ST_DONE;
        case (op)
            spq_pkg::OP_INSERT: begin
                if (full) begin
                    status_next = spq_pkg::ST_FULL;
                end else begin
                    occ_next = occ_reg + CntW'(1);
                end
            end
            spq_pkg::OP_REMOVE: begin
                if (!found) begin
                    status_next = spq_pkg::ST_NO_MATCH;
                end else begin
                    occ_next = occ_reg - CntW'(1);
                end
            end
            default: begin
                occ_next = occ_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                occ_reg <= occ_next;
            end
            if (s_accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload, captured from the head cell's next contents.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            status_reg <= status_next;
            count_reg  <= spq_pkg::COUNT_W'(occ_next);
            if (nxt[0].valid) begin
                head_reg <= nxt[0];
            end else begin
                head_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {2'b00, head_reg.prio, head_reg.value, head_reg.valid, count_reg};

endmodule

`default_nettype wire

// File: rtl/core/spq_checker.sv
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_queue_macros.svh"

module spq_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [spq_pkg::M_DATA_W-1:0]  m_tdata,
    input wire logic [spq_pkg::STATUS_W-1:0]  m_tuser
);

    logic [spq_pkg::COUNT_W-1:0] count_w;
    logic                        head_valid_w;
    logic [spq_pkg::VALUE_W-1:0] head_value_w;
    logic [spq_pkg::PRIO_W-1:0]  head_prio_w;

    assign count_w      = m_tdata[4:0];
    assign head_valid_w = m_tdata[5];
    assign head_value_w = m_tdata[37:6];
    assign head_prio_w  = m_tdata[53:38];

    // An accepted word always yields a result in the next cycle.
    `SPQ_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid, "missing result word")

    // A stalled result word holds.
    `SPQ_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // An empty head reports zero fields.
    `SPQ_ASSERT_NOW(a_empty_head, m_tvalid && !head_valid_w, count_w == '0 && head_value_w == '0 && head_prio_w == '0, "empty head not zero")

    // A full rejection reports the queue at capacity with a head present.
    `SPQ_ASSERT_NOW(a_full_count, m_tvalid && m_tuser == spq_pkg::ST_FULL, count_w == spq_pkg::COUNT_W'(DEPTH) && head_valid_w, "full status with wrong count")

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
